// ----- rtl/gcc_pkg.sv -----
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared types, constants and lookup tables for the gesture centroid
// classifier.
// ----------------------------------------------------------------------------
package gcc_pkg;

  localparam int CLASS_COUNT_DEF = 11;
  localparam int TABLE_ROWS      = 11;
  localparam int FEATS           = 5;
  localparam int FEAT_W          = 12;   // signed Q1.10, -1024..1024
  localparam int M_W             = 12;   // weighted distance term
  localparam int SUM_W           = 26;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [15:0] HOLD_MS_RST   = 16'd350;
  localparam logic [15:0] COOLDOWN_RST  = 16'd1200;
  localparam logic [7:0]  TREMOR_THR_RST = 8'd70;
  localparam logic [15:0] SUSTAIN_RST   = 16'd800;
  localparam logic [7:0]  SPASM_CONF    = 8'd250;

  // register indexes
  localparam logic [1:0] REG_HOLD     = 2'd0;
  localparam logic [1:0] REG_COOLDOWN = 2'd1;
  localparam logic [1:0] REG_THRESH   = 2'd2;
  localparam logic [1:0] REG_SUSTAIN  = 2'd3;

  // event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_GESTURE = 2'd1;
  localparam logic [1:0] EV_SPASM   = 2'd2;

  localparam logic signed [FEAT_W-1:0] LO = 12'sd154;
  localparam logic signed [FEAT_W-1:0] HI = 12'sd819;
  localparam logic signed [FEAT_W-1:0] EM = 12'sd870;
  localparam logic signed [FEAT_W-1:0] TL = 12'sd870;
  localparam logic signed [FEAT_W-1:0] ZR = 12'sd0;

  localparam logic signed [FEAT_W-1:0] CENTROID [0:TABLE_ROWS-1][0:FEATS-1] = '{
    '{LO, LO, LO, ZR, ZR},
    '{HI, LO, LO, ZR, ZR},
    '{LO, HI, LO, ZR, ZR},
    '{LO, LO, HI, ZR, ZR},
    '{EM, EM, EM, ZR, ZR},
    '{HI, LO, LO, ZR, -TL},
    '{LO, HI, LO, ZR, -TL},
    '{LO, LO, HI, ZR, -TL},
    '{HI, LO, LO, ZR, TL},
    '{LO, HI, LO, ZR, TL},
    '{LO, LO, HI, ZR, TL}
  };

  localparam logic [8:0] WEIGHT [0:FEATS-1] = '{9'd333, 9'd333, 9'd333, 9'd256, 9'd461};

  typedef logic [10:0] flex_lut_t  [0:100];
  typedef logic [10:0] angle_lut_t [0:90];

  function automatic flex_lut_t build_flex_lut();
    flex_lut_t lut;
    for (int i = 0; i <= 100; i++) begin
      lut[i] = 11'((i * 1024 + 50) / 100);
    end
    return lut;
  endfunction

  function automatic angle_lut_t build_angle_lut();
    angle_lut_t lut;
    for (int i = 0; i <= 90; i++) begin
      lut[i] = 11'((i * 1024 + 45) / 90);
    end
    return lut;
  endfunction

  typedef struct packed {
    logic [15:0] hold_ms;
    logic [15:0] cooldown_ms;
    logic [7:0]  tremor_threshold;
    logic [15:0] tremor_sustain_ms;
  } cfg_t;

  typedef struct packed {
    logic [FEATS-1:0][FEAT_W-1:0] feat;
    logic [7:0]                   tremor_level;
    logic [31:0]                  time_ms;
  } item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [3:0] gesture_class;
    logic [7:0] confidence_q8;
    logic       fire_action;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQ,
    ST_SQRT,
    ST_FIN
  } back_state_t;

endpackage

// ----- rtl/gesture_centroid_classifier_hold.sv -----
// ----------------------------------------------------------------------------
// gesture_centroid_classifier_hold
// Glove sample classifier: nearest weighted centroid, hold confirmation,
// spasm detection from sustained tremor, action cooldown.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     push / full          flex_a..c, pitch_deg, roll_deg, tremor_level, time_ms
//  result    pop / empty          event_kind, gesture_class, confidence_q8, fire_action
//  config    cfg_we               cfg_addr, cfg_wdata
//
//  A classified item steps through every centroid row on the shared distance
//  unit, a multiply state and a square-sum state per row, and then through
//  the bit-serial square root. A spasm item is finished when it is popped.
//  rst is synchronous and restores the register defaults and clears state.
//  A two-item queue lets the front keep taking items while the back waits
//  for its result register to be popped.
// ----------------------------------------------------------------------------
module gesture_centroid_classifier_hold import gcc_pkg::*; #(
  parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input items
  input  logic               push,
  output logic               full,
  input  logic        [7:0]  flex_a,
  input  logic        [7:0]  flex_b,
  input  logic        [7:0]  flex_c,
  input  logic signed [7:0]  pitch_deg,
  input  logic signed [7:0]  roll_deg,
  input  logic        [7:0]  tremor_level,
  input  logic        [31:0] time_ms,
  // result items
  output logic               empty,
  input  logic               pop,
  output logic        [1:0]  event_kind,
  output logic        [3:0]  gesture_class,
  output logic        [7:0]  confidence_q8,
  output logic               fire_action,
  // configuration
  input  logic               cfg_we,
  input  logic        [1:0]  cfg_addr,
  input  logic        [15:0] cfg_wdata
);

  cfg_t  cfg;
  item_t f_item;
  item_t q_item;
  logic  q_empty;
  logic  q_pop;
  res_t  res;
  logic  res_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ms           <= HOLD_MS_RST;
      cfg.cooldown_ms       <= COOLDOWN_RST;
      cfg.tremor_threshold  <= TREMOR_THR_RST;
      cfg.tremor_sustain_ms <= SUSTAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HOLD:     cfg.hold_ms           <= cfg_wdata;
        REG_COOLDOWN: cfg.cooldown_ms       <= cfg_wdata;
        REG_THRESH:   cfg.tremor_threshold  <= cfg_wdata[7:0];
        REG_SUSTAIN:  cfg.tremor_sustain_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front: clamp and normalize
  gcc_front u_front (
    .flex_a       (flex_a),
    .flex_b       (flex_b),
    .flex_c       (flex_c),
    .pitch_deg    (pitch_deg),
    .roll_deg     (roll_deg),
    .tremor_level (tremor_level),
    .time_ms      (time_ms),
    .item         (f_item)
  );

  // decoupling queue
  gcc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (push && !full),
    .wr_item (f_item),
    .full    (full),
    .rd      (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  // back: tremor, search, sqrt, hold, cooldown; holds one result
  gcc_back #(
    .CLASS_COUNT (CLASS_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_item    (q_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop)
  );

  assign empty         = !res_valid;
  assign event_kind    = res.event_kind;
  assign gesture_class = res.gesture_class;
  assign confidence_q8 = res.confidence_q8;
  assign fire_action   = res.fire_action;

endmodule

// ----- rtl/gcc_front.sv -----
// ----------------------------------------------------------------------------
// gcc_front
// Clamps and normalizes one raw sample into Q1.10 features.
// ----------------------------------------------------------------------------
module gcc_front import gcc_pkg::*; (
  input  logic        [7:0]  flex_a,
  input  logic        [7:0]  flex_b,
  input  logic        [7:0]  flex_c,
  input  logic signed [7:0]  pitch_deg,
  input  logic signed [7:0]  roll_deg,
  input  logic        [7:0]  tremor_level,
  input  logic        [31:0] time_ms,
  output item_t              item
);

  localparam flex_lut_t  FLEX_LUT  = build_flex_lut();
  localparam angle_lut_t ANGLE_LUT = build_angle_lut();

  function automatic logic [FEAT_W-1:0] norm_flex(input logic [7:0] f);
    logic [6:0] c;
    c = (f > 8'd100) ? 7'd100 : f[6:0];
    return {1'b0, FLEX_LUT[c]};
  endfunction

  function automatic logic [FEAT_W-1:0] norm_angle(input logic signed [7:0] a);
    logic [7:0]  mag;
    logic [6:0]  c;
    logic [FEAT_W-1:0] q;
    mag = a[7] ? (8'd0 - a) : a;   // 128 for -128
    c   = (mag > 8'd90) ? 7'd90 : mag[6:0];
    q   = {1'b0, ANGLE_LUT[c]};
    return a[7] ? (12'd0 - q) : q;
  endfunction

  always_comb begin
    item.feat[0]      = norm_flex(flex_a);
    item.feat[1]      = norm_flex(flex_b);
    item.feat[2]      = norm_flex(flex_c);
    item.feat[3]      = norm_angle(pitch_deg);
    item.feat[4]      = norm_angle(roll_deg);
    item.tremor_level = tremor_level;
    item.time_ms      = time_ms;
  end

endmodule

// ----- rtl/gcc_queue.sv -----
// ----------------------------------------------------------------------------
// gcc_queue
// Short item queue between the front and back parts.
// ----------------------------------------------------------------------------
module gcc_queue import gcc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd,
  output item_t rd_item,
  output logic  empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t          mem [0:QUEUE_DEPTH-1];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;

  assign full    = (count == (PW+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/gcc_back.sv -----
// ----------------------------------------------------------------------------
// gcc_back
// Tremor timing, nearest-centroid search, square root, hold and cooldown.
// ----------------------------------------------------------------------------
module gcc_back import gcc_pkg::*; #(
  parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  item_t q_item,
  input  logic  q_empty,
  output logic  q_pop,
  output res_t  res,
  output logic  res_valid,
  input  logic  res_pop
);

  localparam int ROWS = (CLASS_COUNT < TABLE_ROWS) ? CLASS_COUNT : TABLE_ROWS;
  localparam int IW   = $clog2(ROWS);
  localparam logic [3:0] SPASM_CODE = 4'(CLASS_COUNT);
  localparam res_t SPASM_RES = '{
    event_kind:    EV_SPASM,
    gesture_class: SPASM_CODE,
    confidence_q8: SPASM_CONF,
    fire_action:   1'b1
  };

  back_state_t state, state_next;

  // control state
  logic        tremor_timing;
  logic [31:0] tremor_start;
  logic [3:0]  cand_class;
  logic [31:0] cand_start;
  logic [3:0]  conf_class;
  logic [31:0] last_trigger;

  // payload
  logic [FEATS-1:0][FEAT_W-1:0] feat;
  logic [31:0]                  now_r;
  logic [IW-1:0]                idx;
  logic [FEATS-1:0][M_W-1:0]    m;
  logic [SUM_W-1:0]             best;
  logic [IW-1:0]                best_id;
  logic [SUM_W-1:0]             sq_x;
  logic [SUM_W-1:0]             sq_r;
  logic [SUM_W-2:0]             sq_bit;

  // tremor decision on the queue head
  logic [31:0] now_q;
  logic        trem_hi;
  logic        sustained;
  logic        cool_q;
  logic        start;

  assign now_q     = q_item.time_ms;
  assign trem_hi   = q_item.tremor_level > cfg.tremor_threshold;
  assign sustained = tremor_timing &&
                     ((now_q - tremor_start) > {16'd0, cfg.tremor_sustain_ms});
  assign cool_q    = (now_q - last_trigger) > {16'd0, cfg.cooldown_ms};
  assign start     = (state == ST_IDLE) && !q_empty && !res_valid;
  assign q_pop     = start;

  // weighted distance terms for one row
  logic [FEATS-1:0][M_W-1:0] m_new;
  always_comb begin
    for (int k = 0; k < FEATS; k++) begin
      logic signed [FEAT_W:0] d;
      logic [FEAT_W-2:0]      a;
      logic [20:0]            p;
      d = {feat[k][FEAT_W-1], feat[k]} - {CENTROID[idx][k][FEAT_W-1], CENTROID[idx][k]};
      a = d[FEAT_W] ? (FEAT_W-1)'(-d) : (FEAT_W-1)'(d);
      p = 21'(a) * 21'(WEIGHT[k]) + 21'd128;
      m_new[k] = M_W'(p >> 8);
    end
  end

  // squared sum and running minimum
  logic [SUM_W-1:0] sum;
  logic             less;
  logic [SUM_W-1:0] best_new;
  always_comb begin
    sum = '0;
    for (int k = 0; k < FEATS; k++) begin
      sum = sum + SUM_W'(m[k]) * SUM_W'(m[k]);
    end
    less     = sum < best;
    best_new = less ? sum : best;
  end

  // one square-root step
  logic [SUM_W:0] sq_t;
  logic           sq_ge;
  assign sq_t  = {1'b0, sq_r} + {2'b0, sq_bit};
  assign sq_ge = {1'b0, sq_x} >= sq_t;

  // confidence
  logic [21:0] loss_w;
  logic [10:0] loss;
  logic [7:0]  conf;
  assign loss_w = 22'd255 * 22'(sq_r[12:0]) + 22'd1024;
  assign loss   = loss_w[21:11];
  assign conf   = (loss >= 11'd255) ? 8'd0 : 8'(11'd255 - loss);

  logic last_row;
  assign last_row = (idx == IW'(ROWS-1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start && !(trem_hi && sustained)) state_next = ST_MUL;
      ST_MUL:  state_next = ST_SQ;
      ST_SQ:   state_next = last_row ? ST_SQRT : ST_MUL;
      ST_SQRT: if (sq_bit == (SUM_W-1)'(1)) state_next = ST_FIN;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid     <= 1'b0;
      tremor_timing <= 1'b0;
      tremor_start  <= '0;
      cand_class    <= '0;
      cand_start    <= '0;
      conf_class    <= '0;
      last_trigger  <= '0;
    end else begin
      if (res_valid && res_pop) res_valid <= 1'b0;
      if (start) begin
        if (trem_hi) begin
          if (!tremor_timing) begin
            tremor_timing <= 1'b1;
            tremor_start  <= now_q;
          end else if (sustained) begin
            res_valid <= 1'b1;
            if (cool_q) last_trigger <= now_q;
          end
        end else begin
          tremor_timing <= 1'b0;
        end
      end
      if (state == ST_FIN) begin
        res_valid <= 1'b1;
        if (4'(best_id) != cand_class) begin
          cand_class <= 4'(best_id);
          cand_start <= now_r;
        end else if (((now_r - cand_start) >= {16'd0, cfg.hold_ms}) &&
                     (conf_class != cand_class)) begin
          conf_class <= cand_class;
          if ((cand_class != 4'd0) &&
              ((now_r - last_trigger) > {16'd0, cfg.cooldown_ms})) begin
            last_trigger <= now_r;
          end
        end
      end
    end
  end

  // datapath and result payload
  always_ff @(posedge clk) begin
    if (start) begin
      feat  <= q_item.feat;
      now_r <= now_q;
      idx   <= '0;
      best  <= '1;
      res   <= (trem_hi && sustained && cool_q) ? SPASM_RES : '0;
    end
    unique case (state)
      ST_MUL: m <= m_new;
      ST_SQ: begin
        best <= best_new;
        if (less) best_id <= idx;
        idx <= idx + 1'b1;
        if (last_row) begin
          sq_x   <= best_new;
          sq_r   <= '0;
          sq_bit <= (SUM_W-1)'(1) << (SUM_W-2);
        end
      end
      ST_SQRT: begin
        if (sq_ge) begin
          sq_x <= sq_x - sq_t[SUM_W-1:0];
          sq_r <= (sq_r >> 1) + {1'b0, sq_bit};
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      ST_FIN: begin
        if ((4'(best_id) == cand_class) &&
            ((now_r - cand_start) >= {16'd0, cfg.hold_ms}) &&
            (conf_class != cand_class)) begin
          res <= '{
            event_kind:    EV_GESTURE,
            gesture_class: cand_class,
            confidence_q8: conf,
            fire_action:   (cand_class != 4'd0) &&
                           ((now_r - last_trigger) > {16'd0, cfg.cooldown_ms})
          };
        end
      end
      default: ;
    endcase
  end

endmodule
